// ===== sv/l1nps_pkg.sv =====
// shared types and constants for the l1 nearest point search block
// no dependencies; imported by the store, merge and top modules of the block
package l1nps_pkg;

	// fixed widths of the port fields
	localparam int NUM_FIELDS  = 4;
	localparam int FIELD_W     = 8;
	localparam int IDX_W       = 6;
	localparam int NP_W        = 7;
	localparam int DIST_OUT_W  = 10;

	// item kinds carried on the action field
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// scan sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// control tag that travels with each stored point through the pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

// ===== sv/l1nps_store.sv =====
// point store: one write port for loads, one registered read port for the scan
// depends on l1nps_pkg (ctl_t)
module l1nps_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WW    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WW-1:0]     wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	input  logic              rlast,
	output logic [WW-1:0]     rdata_s1,
	output logic [AW-1:0]     idx_s1,
	output l1nps_pkg::ctl_t   ctl_s1
);
	import l1nps_pkg::*;

	logic [WW-1:0] mem_q [DEPTH];

	// storage array and read data register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
			idx_s1   <= raddr;
		end
	end

	// read tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= re;
			ctl_s1.last  <= re && rlast;
		end
	end

endmodule

// ===== sv/l1nps_lane.sv =====
// one coordinate lane: registered absolute difference of stored and query coordinate
// depends on nothing beyond its parameter
module l1nps_lane #(
	parameter int CW = 8
) (
	input  logic          clk,
	input  logic [CW-1:0] a,
	input  logic [CW-1:0] b,
	output logic [CW-1:0] diff_s2
);

	logic [CW-1:0] diff;

	// absolute difference fits the coordinate width
	always_comb begin
		if (a >= b) begin
			diff = a - b;
		end else begin
			diff = b - a;
		end
	end

	always_ff @(posedge clk) begin
		diff_s2 <= diff;
	end

endmodule

// ===== sv/l1nps_merge.sv =====
// merge stage: sums the lane differences and keeps the running minimum
// depends on l1nps_pkg (ctl_t)
module l1nps_merge #(
	parameter int DIMS = 4,
	parameter int CW   = 8,
	parameter int AW   = 6,
	parameter int DW   = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DIMS*CW-1:0] diff_s2,
	input  logic [AW-1:0]     idx_s2,
	input  l1nps_pkg::ctl_t   ctl_s2,
	output logic [AW-1:0]     best_idx_q,
	output logic [DW-1:0]     best_dist_q,
	output logic              done_q
);
	import l1nps_pkg::*;

	logic [DW-1:0] sum;
	logic [DW-1:0] sum_s3;
	logic [AW-1:0] idx_s3;
	ctl_t          ctl_s3;
	logic          take;

	// add the lane differences
	always_comb begin
		sum = '0;
		for (int d = 0; d < DIMS; d++) begin
			sum = sum + DW'(diff_s2[d*CW +: CW]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum;
		idx_s3 <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	// entry 0 opens every scan; later entries win only when strictly closer
	assign take = ctl_s3.valid && ((idx_s3 == '0) || (sum_s3 < best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= sum_s3;
			best_idx_q  <= idx_s3;
		end
	end

	// end of scan marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s3.valid && ctl_s3.last;
		end
	end

endmodule

// ===== sv/l1_nearest_point_search.sv =====
// Nearest stored point by L1 distance. A load beat (action 0) writes one point into the
// store. A query beat (action 1) reads entries 0 .. num_points-1 (num_points taken as 1 when
// zero and as MAX_POINTS when larger) one per cycle from the single read port of the point
// store; the block takes no new beat until the result has moved into the output register.
// DIMS lanes form the absolute differences side by side and a merge stage sums them and
// keeps the lowest index among equal distances. A finished result waits in the output
// register while loads go on. Entries never loaded read as undefined data.
// depends on l1nps_pkg, l1nps_store, l1nps_lane, l1nps_merge
module l1_nearest_point_search #(
	parameter int MAX_POINTS = 64,
	parameter int DIMS       = 4,
	parameter int COORD_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [l1nps_pkg::NP_W-1:0]            cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [l1nps_pkg::IDX_W-1:0]           point_index,
	input  logic [l1nps_pkg::FIELD_W-1:0]         coord0,
	input  logic [l1nps_pkg::FIELD_W-1:0]         coord1,
	input  logic [l1nps_pkg::FIELD_W-1:0]         coord2,
	input  logic [l1nps_pkg::FIELD_W-1:0]         coord3,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [l1nps_pkg::IDX_W-1:0]           closest_index,
	output logic [l1nps_pkg::DIST_OUT_W-1:0]      min_distance
);
	import l1nps_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = COORD_BITS;
	localparam int WW = DIMS * CW;
	localparam int DW = CW + $clog2(DIMS);
	localparam logic [31:0] MAX_P = 32'(MAX_POINTS);

	state_t            state_q, state_d;
	logic [NP_W-1:0]   num_points_q;
	logic [AW-1:0]     addr_q, last_q;
	logic [31:0]       last_w;
	logic [FIELD_W-1:0] coord_in [NUM_FIELDS];
	logic [2*FIELD_W-1:0] field_ext [NUM_FIELDS];
	logic [WW-1:0]     in_word;
	logic [WW-1:0]     qry_q;
	logic              in_acc, qry_acc, load_we, rd_en, rd_last;
	logic [31:0]       widx_w;
	logic [WW-1:0]     rd_word_s1;
	logic [AW-1:0]     idx_s1, idx_s2;
	ctl_t              ctl_s1, ctl_s2;
	logic [WW-1:0]     diff_s2;
	logic [AW-1:0]     best_idx;
	logic [DW-1:0]     best_dist;
	logic              done;
	logic              res_pend_q, xfer;
	logic              out_valid_q;
	logic [31:0]       res_idx_w, res_dist_w;
	logic [IDX_W-1:0]  closest_index_q;
	logic [DIST_OUT_W-1:0] min_distance_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= NP_W'(1);
		end else if (cfg_we) begin
			num_points_q <= cfg_wdata;
		end
	end

	// input coordinates masked to the coordinate width
	assign coord_in[0] = coord0;
	assign coord_in[1] = coord1;
	assign coord_in[2] = coord2;
	assign coord_in[3] = coord3;

	for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_ext
		assign field_ext[f] = {{FIELD_W{1'b0}}, coord_in[f]};
	end

	for (genvar d = 0; d < DIMS; d++) begin : g_word
		if (d < NUM_FIELDS) begin : g_field
			assign in_word[d*CW +: CW] = field_ext[d][CW-1:0];
		end else begin : g_zero
			assign in_word[d*CW +: CW] = '0;
		end
	end

	// handshake and load decode
	assign in_acc  = in_valid && in_ready;
	assign qry_acc = in_acc && (action == ACT_QUERY);
	assign widx_w  = 32'(point_index);
	assign load_we = in_acc && (action == ACT_LOAD) && (widx_w < MAX_P);

	// last entry searched, clamped to the store
	always_comb begin
		priority if (num_points_q == '0) begin
			last_w = '0;
		end else if (32'(num_points_q) > MAX_P) begin
			last_w = MAX_P - 32'd1;
		end else begin
			last_w = 32'(num_points_q) - 32'd1;
		end
	end

	assign rd_last = (addr_q == last_q);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (qry_acc) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (rd_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (xfer) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  rd_en    = 1'b1;
			ST_DRAIN: ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			last_q  <= '0;
		end else begin
			state_q <= state_d;
			if (qry_acc) begin
				addr_q <= '0;
				last_q <= last_w[AW-1:0];
			end else if (rd_en) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	// query point held for the whole scan
	always_ff @(posedge clk) begin
		if (qry_acc) begin
			qry_q <= in_word;
		end
	end

	l1nps_store #(
		.DEPTH (MAX_POINTS),
		.AW    (AW),
		.WW    (WW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (load_we),
		.waddr    (widx_w[AW-1:0]),
		.wdata    (in_word),
		.re       (rd_en),
		.raddr    (addr_q),
		.rlast    (rd_last),
		.rdata_s1 (rd_word_s1),
		.idx_s1   (idx_s1),
		.ctl_s1   (ctl_s1)
	);

	// one lane per coordinate
	for (genvar d = 0; d < DIMS; d++) begin : g_lane
		l1nps_lane #(
			.CW (CW)
		) u_lane (
			.clk     (clk),
			.a       (rd_word_s1[d*CW +: CW]),
			.b       (qry_q[d*CW +: CW]),
			.diff_s2 (diff_s2[d*CW +: CW])
		);
	end

	// tag alongside the lane registers
	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	l1nps_merge #(
		.DIMS (DIMS),
		.CW   (CW),
		.AW   (AW),
		.DW   (DW)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.diff_s2     (diff_s2),
		.idx_s2      (idx_s2),
		.ctl_s2      (ctl_s2),
		.best_idx_q  (best_idx),
		.best_dist_q (best_dist),
		.done_q      (done)
	);

	// result hand-off into the output register
	assign xfer = res_pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				res_pend_q <= 1'b1;
			end else if (xfer) begin
				res_pend_q <= 1'b0;
			end
			if (xfer) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_idx_w  = 32'(best_idx);
	assign res_dist_w = 32'(best_dist);

	always_ff @(posedge clk) begin
		if (xfer) begin
			closest_index_q <= res_idx_w[IDX_W-1:0];
			min_distance_q  <= res_dist_w[DIST_OUT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign closest_index = closest_index_q;
	assign min_distance  = min_distance_q;

`ifndef SYNTHESIS
	// no result may be pending while a new beat can be taken
	a_ready_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_pend_q)
		else $error("result pending while input ready");

	// the end of a scan only reaches the merge stage while draining
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_DRAIN))
		else $error("scan end outside drain state");

	// scan address stays inside the searched range
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (addr_q <= last_q))
		else $error("scan address beyond last entry");

	// an accepted query starts its scan at entry zero
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		qry_acc |=> ((state_q == ST_SCAN) && (addr_q == '0)))
		else $error("query did not start scan at entry zero");
`endif

endmodule

// ===== test/tb_l1_nearest_point_search.sv =====
// self-checking testbench for l1_nearest_point_search: point loads, nearest-point queries
// and point-count settings, results checked against an in-bench store and search
// depends on l1nps_pkg and the l1_nearest_point_search rtl
module tb_l1_nearest_point_search;
	import l1nps_pkg::*;

	localparam int STORE_DEPTH    = 64;
	localparam int DIMS           = 4;
	localparam int CFG_SETTLE     = 12;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef logic [DIMS-1:0][FIELD_W-1:0] point_t;

	typedef struct {
		logic [IDX_W-1:0]      idx;
		logic [DIST_OUT_W-1:0] distance;
	} nearest_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [NP_W-1:0]       cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [IDX_W-1:0]      point_index;
	logic [FIELD_W-1:0]    coord0;
	logic [FIELD_W-1:0]    coord1;
	logic [FIELD_W-1:0]    coord2;
	logic [FIELD_W-1:0]    coord3;
	logic                  out_valid;
	logic                  out_ready;
	logic [IDX_W-1:0]      closest_index;
	logic [DIST_OUT_W-1:0] min_distance;

	// shadow of the block: stored points and the point count
	point_t    shadow_points [STORE_DEPTH];
	logic      [NP_W-1:0] shadow_count;
	nearest_t  expected_nearest [$];

	int  n_errors;
	int  n_loads;
	int  n_queries;
	int  n_cfg;
	int  n_checked;
	int  idle_cycles;
	bit  no_gaps;

	l1_nearest_point_search i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.point_index   (point_index),
		.coord0        (coord0),
		.coord1        (coord1),
		.coord2        (coord2),
		.coord3        (coord3),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.closest_index (closest_index),
		.min_distance  (min_distance)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// search of the shadow store, lowest index kept on equal distance
	function automatic nearest_t find_nearest(input point_t q);
		nearest_t best;
		int span;
		int sum;
		span = (shadow_count == 0) ? 1 :
			((shadow_count > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_count));
		best.idx      = '0;
		best.distance = '0;
		for (int i = 0; i < span; i++) begin
			sum = 0;
			for (int d = 0; d < DIMS; d++) begin
				if (shadow_points[i][d] >= q[d]) sum += shadow_points[i][d] - q[d];
				else sum += q[d] - shadow_points[i][d];
			end
			if (i == 0 || sum < int'(best.distance)) begin
				best.idx      = IDX_W'(i);
				best.distance = DIST_OUT_W'(sum);
			end
		end
		return best;
	endfunction

	// coordinate biased toward the ends of the range; tight keeps it in 0..3
	function automatic logic [FIELD_W-1:0] pick_coord(input bit tight);
		int sel;
		sel = $urandom_range(0, 7);
		if (tight) return FIELD_W'($urandom_range(0, 3));
		case (sel)
			0: return '0;
			1: return '1;
			2: return FIELD_W'($urandom_range(0, 3));
			default: return FIELD_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic point_t pick_point(input bit tight);
		point_t p;
		for (int d = 0; d < DIMS; d++) p[d] = pick_coord(tight);
		return p;
	endfunction

	// one input beat; valid stays high across back-to-back beats
	task automatic send_beat(input logic act, input logic [IDX_W-1:0] idx, input point_t c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		point_index <= idx;
		coord0      <= c[0];
		coord1      <= c[1];
		coord2      <= c[2];
		coord3      <= c[3];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// beat taken at this edge: update the shadow in acceptance order
		if (act == ACT_LOAD) begin
			shadow_points[idx] = c;
			n_loads++;
		end else begin
			expected_nearest.push_back(find_nearest(c));
			n_queries++;
		end
	endtask

	// stop sending and wait for every pending result
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_nearest.size() != 0);
	endtask

	task automatic set_point_count(input logic [NP_W-1:0] v);
		wait_results_drained();
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_count  = v;
		n_cfg++;
	endtask

	// mixed loads and queries over a fully written store
	task automatic random_traffic(input int n, input bit tight);
		point_t p;
		int span;
		for (int k = 0; k < n; k++) begin
			span = (shadow_count == 0) ? 1 :
				((shadow_count > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_count));
			if ($urandom_range(0, 99) < 55) begin
				// query: sometimes an exact copy of a searched point
				if ($urandom_range(0, 3) == 0) p = shadow_points[$urandom_range(0, span - 1)];
				else p = pick_point(tight);
				send_beat(ACT_QUERY, IDX_W'($urandom_range(0, 63)), p);
			end else begin
				// load: sometimes a duplicate of another entry to force ties
				if ($urandom_range(0, 5) == 0) p = shadow_points[$urandom_range(0, 63)];
				else p = pick_point(tight);
				send_beat(ACT_LOAD, IDX_W'($urandom_range(0, 63)), p);
			end
		end
	endtask

	// reset value of the point count searches entry 0 only
	task automatic test_default_count();
		send_beat(ACT_LOAD, 6'd0, '0);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd63, '0);
	endtask

	// field extremes, ties to the lowest index, zero point count
	task automatic test_extremes();
		send_beat(ACT_LOAD, 6'd1, '1);
		send_beat(ACT_LOAD, 6'd2, '0);
		send_beat(ACT_LOAD, 6'd3, {8'h7f, 8'h80, 8'hff, 8'h00});
		set_point_count(7'd4);
		send_beat(ACT_QUERY, 6'd0, '0);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd63, {8'h7f, 8'h80, 8'hff, 8'h00});
		send_beat(ACT_QUERY, 6'd21, {8'h55, 8'haa, 8'h55, 8'haa});
		send_beat(ACT_QUERY, 6'd42, {8'h80, 8'h80, 8'h80, 8'h80});
		set_point_count(7'd1);
		send_beat(ACT_QUERY, 6'd0, '1);
		set_point_count(7'd0);
		send_beat(ACT_QUERY, 6'd0, '1);
		send_beat(ACT_QUERY, 6'd0, {8'h01, 8'h02, 8'h04, 8'h08});
	endtask

	// write every entry so that any count can be searched
	task automatic test_fill_store();
		send_beat(ACT_LOAD, 6'd63, {8'haa, 8'h55, 8'haa, 8'h55});
		for (int i = 0; i < STORE_DEPTH - 1; i++)
			send_beat(ACT_LOAD, IDX_W'(i), pick_point(1'b0));
	endtask

	// point count settings across the range, above the store size too
	task automatic test_count_sweep();
		logic [NP_W-1:0] counts [8];
		counts = '{7'd64, 7'd127, 7'd65, 7'd1, 7'd2, 7'd0, 7'd33, 7'd3};
		counts[6] = NP_W'($urandom_range(3, 63));
		foreach (counts[i]) begin
			set_point_count(counts[i]);
			random_traffic(28, 1'b0);
		end
	endtask

	// small coordinates, many equal distances
	task automatic test_ties();
		set_point_count(7'd64);
		random_traffic(40, 1'b1);
	endtask

	// back-to-back beats on both sides
	task automatic test_no_gaps();
		set_point_count(NP_W'($urandom_range(8, 64)));
		no_gaps = 1'b1;
		random_traffic(30, 1'b0);
		no_gaps = 1'b0;
	endtask

	// sender holds off until the block has no result pending
	task automatic test_drain_pause();
		set_point_count(7'd16);
		random_traffic(15, 1'b0);
		wait_results_drained();
		random_traffic(15, 1'b0);
	endtask

	// result sink with random stalls
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		nearest_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_nearest.size() == 0) begin
				report_mismatch($sformatf("unexpected result index %0d distance %0d",
					closest_index, min_distance));
			end else begin
				want = expected_nearest.pop_front();
				n_checked++;
				if (closest_index !== want.idx)
					report_mismatch($sformatf("closest_index %0d, want %0d",
						closest_index, want.idx));
				if (min_distance !== want.distance)
					report_mismatch($sformatf("min_distance %0d, want %0d",
						min_distance, want.distance));
			end
		end
	end

	// count cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no beat for %0d cycles, %0d results pending",
			idle_cycles, expected_nearest.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		n_errors     = 0;
		n_loads      = 0;
		n_queries    = 0;
		n_cfg        = 0;
		n_checked    = 0;
		idle_cycles  = 0;
		no_gaps      = 1'b0;
		shadow_count = 7'd1;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		in_valid    <= 1'b0;
		action      <= ACT_LOAD;
		point_index <= '0;
		coord0      <= '0;
		coord1      <= '0;
		coord2      <= '0;
		coord3      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_count();
		test_extremes();
		test_fill_store();
		test_count_sweep();
		test_ties();
		test_no_gaps();
		test_drain_pause();

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_nearest.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_nearest.size()));

		$display("covered %0d point loads and %0d queries over %0d point-count settings",
			n_loads, n_queries, n_cfg);
		$display("%0d results checked, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
